### rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helper functions for the chunked body
// decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int LEN_BITS_DEF = 32;
	localparam int HEX_BITS     = 4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [1:0] END_TERMINATOR = 2'd0;
	localparam logic [1:0] END_NO_DIGITS  = 2'd1;
	localparam logic [1:0] END_TRUNCATED  = 2'd2;

	typedef enum logic [2:0] {
		PH_SKIPWS  = 3'd0,
		PH_SIGNED  = 3'd1,
		PH_ZERO    = 3'd2,
		PH_XPREFIX = 3'd3,
		PH_DIGITS  = 3'd4,
		PH_EOL     = 3'd5,
		PH_PAYLOAD = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_last;
	} item_t;

	typedef struct packed {
		logic       has_result;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       body_done;
		logic [1:0] end_code;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LA) && (c <= CH_LF_HEX)) ||
			((c >= CH_UA) && (c <= CH_UF));
	endfunction

	function automatic logic [HEX_BITS-1:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
			v = c - CH_ZERO;
		end else if ((c >= CH_LA) && (c <= CH_LF_HEX)) begin
			v = c - CH_LA + 8'd10;
		end else begin
			v = c - CH_UA + 8'd10;
		end
		return v[HEX_BITS-1:0];
	endfunction

endpackage

### rtl/hcbd_in_stage.sv
// ----------------------------------------------------------------------------
// hcbd_in_stage
// Input register that holds one body word until the parser can retire it.
// ----------------------------------------------------------------------------
module hcbd_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hcbd_pkg::item_t in_item,
	input  logic          out_space,
	output logic          step,
	output hcbd_pkg::item_t item_s1
);
	import hcbd_pkg::*;

	logic valid_s1;

	assign step     = valid_s1 && out_space;
	assign in_ready = !valid_s1 || out_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/hcbd_parser.sv
// ----------------------------------------------------------------------------
// hcbd_parser
// Size line parser and payload counter; retires one word per step.
// ----------------------------------------------------------------------------
module hcbd_parser #(
	parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hcbd_pkg::item_t   item_s1,
	output hcbd_pkg::result_t result
);
	import hcbd_pkg::*;

	localparam int WIDE_BITS = LEN_BITS + HEX_BITS;

	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] size_q, size_d;
	logic                neg_q, neg_d;
	logic                cr_q, cr_d;
	logic [LEN_BITS-1:0] rem_q, rem_d;
	logic                fin_q, fin_d;

	logic [7:0]          c;
	logic                last;
	logic                hex;
	logic [HEX_BITS-1:0] dval;
	logic [WIDE_BITS-1:0] acc_wide;
	logic [LEN_BITS-1:0] acc;
	logic                do_first;
	logic                do_num;
	logic                do_eol;
	logic                cr_in;
	logic                pay;
	logic                ended;
	logic [1:0]          code;

	assign c        = item_s1.body_byte;
	assign last     = item_s1.body_last;
	assign hex      = is_hex(c);
	assign dval     = hex_value(c);
	assign acc_wide = {size_q, {HEX_BITS{1'b0}}} + WIDE_BITS'(dval);
	assign acc      = (acc_wide[WIDE_BITS-1 -: HEX_BITS] != '0) ? {LEN_BITS{1'b1}} :
		acc_wide[LEN_BITS-1:0];

	always_comb begin
		phase_d  = phase_q;
		size_d   = size_q;
		neg_d    = neg_q;
		cr_d     = cr_q;
		rem_d    = rem_q;
		fin_d    = fin_q;
		do_first = 1'b0;
		do_num   = 1'b0;
		do_eol   = 1'b0;
		cr_in    = cr_q;
		pay      = 1'b0;
		ended    = 1'b0;
		code     = END_TERMINATOR;

		if (fin_q) begin
			if (last) begin
				phase_d = PH_SKIPWS;
				size_d  = '0;
				neg_d   = 1'b0;
				cr_d    = 1'b0;
				rem_d   = '0;
				fin_d   = 1'b0;
			end
		end else begin
			unique case (phase_q) inside
				PH_SKIPWS: begin
					if (is_space(c)) begin
						phase_d = PH_SKIPWS;
					end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
						neg_d   = (c == CH_MINUS);
						phase_d = PH_SIGNED;
					end else begin
						do_first = 1'b1;
					end
				end
				PH_SIGNED: begin
					do_first = 1'b1;
				end
				PH_ZERO: begin
					if ((c == CH_LX) || (c == CH_UX)) begin
						phase_d = PH_XPREFIX;
					end else begin
						do_num = 1'b1;
					end
				end
				PH_XPREFIX, PH_DIGITS: begin
					do_num = 1'b1;
				end
				PH_EOL: begin
					do_eol = 1'b1;
				end
				PH_PAYLOAD: begin
					pay = 1'b1;
					rem_d = rem_q - LEN_BITS'(1);
					if (rem_q == LEN_BITS'(1)) begin
						phase_d = PH_SKIPWS;
						size_d  = '0;
						neg_d   = 1'b0;
						cr_d    = 1'b0;
						rem_d   = '0;
					end
				end
				default: begin
					phase_d = PH_SKIPWS;
					size_d  = '0;
					neg_d   = 1'b0;
					cr_d    = 1'b0;
					rem_d   = '0;
				end
			endcase

			if (do_first) begin
				if (c == CH_ZERO) begin
					size_d  = '0;
					phase_d = PH_ZERO;
				end else if (hex) begin
					size_d  = LEN_BITS'(dval);
					phase_d = PH_DIGITS;
				end else begin
					ended = 1'b1;
					code  = END_NO_DIGITS;
				end
			end

			if (do_num) begin
				if (hex) begin
					size_d  = acc;
					phase_d = PH_DIGITS;
				end else begin
					do_eol = 1'b1;
					cr_in  = 1'b0;
				end
			end

			if (do_eol) begin
				phase_d = PH_EOL;
				if (cr_in && (c == CH_LF)) begin
					cr_d = 1'b0;
					if (neg_q || (size_q == '0)) begin
						ended = 1'b1;
						code  = END_TERMINATOR;
					end else begin
						rem_d   = size_q;
						phase_d = PH_PAYLOAD;
					end
				end else begin
					cr_d = (c == CH_CR);
				end
			end

			if (!ended && last) begin
				ended = 1'b1;
				code  = ((phase_d == PH_SKIPWS) || (phase_d == PH_SIGNED)) ?
					END_NO_DIGITS : END_TRUNCATED;
			end

			if (ended) begin
				if (last) begin
					phase_d = PH_SKIPWS;
					size_d  = '0;
					neg_d   = 1'b0;
					cr_d    = 1'b0;
					rem_d   = '0;
					fin_d   = 1'b0;
				end else begin
					fin_d = 1'b1;
				end
			end
		end

		result.has_result    = pay || ended;
		result.payload_valid = pay;
		result.payload_byte  = pay ? c : 8'd0;
		result.body_done     = ended;
		result.end_code      = ended ? code : END_TERMINATOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIPWS;
			size_q  <= '0;
			neg_q   <= 1'b0;
			cr_q    <= 1'b0;
			rem_q   <= '0;
			fin_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			neg_q   <= neg_d;
			cr_q    <= cr_d;
			rem_q   <= rem_d;
			fin_q   <= fin_d;
		end
	end

endmodule

### rtl/hcbd_out_reg.sv
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register that holds one decoded word until it is taken.
// ----------------------------------------------------------------------------
module hcbd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hcbd_pkg::result_t result,
	output logic              out_space,
	output logic              out_valid,
	input  logic              out_ready,
	output hcbd_pkg::result_t result_q
);
	import hcbd_pkg::*;

	logic load;

	assign out_space = !out_valid || out_ready;
	assign load      = step && result.has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

### rtl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Decodes an HTTP chunked body one byte word per cycle when not stalled and
// passes on only the payload bytes. Each size line may start with whitespace,
// a sign and a 0x prefix; the hex length saturates at LEN_BITS bits and the
// rest of the line up to CR LF is ignored. A word is returned only for a
// payload byte or for the end of the body, with end_code 0 for a zero or
// negative size, 1 for a size line without digits and 2 for input that ends
// early. Bytes after the end are dropped up to and including the next word
// with body_last set. The block takes one word per cycle when out_ready does
// not stall it: the whole parse step is one short update between the input
// register and the result register, and each register takes a new word in
// the cycle its word leaves, so throughput is limited only by the consumer.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
	parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] body_byte,
	input  logic       body_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic       body_done,
	output logic [1:0] end_code
);
	import hcbd_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	result_t result;
	result_t result_q;
	logic    step;
	logic    out_space;

	assign in_item.body_byte = body_byte;
	assign in_item.body_last = body_last;

	hcbd_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_space (out_space),
		.step      (step),
		.item_s1   (item_s1)
	);

	hcbd_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.result  (result)
	);

	hcbd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.result    (result),
		.out_space (out_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign payload_valid = result_q.payload_valid;
	assign payload_byte  = result_q.payload_byte;
	assign body_done     = result_q.body_done;
	assign end_code      = result_q.end_code;

endmodule
